// ===== rtl/core/max_priority_queue_core_defines.svh =====
// Assertion macros for the max priority queue core.
`ifndef MAX_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define MAX_PRIORITY_QUEUE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked outside reset only.
`define MPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("max_priority_queue_core assertion failed");
// Checked on every clock edge, reset included.
`define MPQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("max_priority_queue_core assertion failed");
`else
`define MPQ_ASSERT(lbl, prop)
`define MPQ_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== rtl/core/mpq_pkg.sv =====
// Shared types and default sizes of the max priority queue core.
package mpq_pkg;

  localparam int unsigned DepthDef        = 16;
  localparam int unsigned PriorityBitsDef = 8;
  localparam int unsigned TagBitsDef      = 16;

  localparam logic CmdInsert = 1'b0;
  localparam logic CmdRemove = 1'b1;

  // Operation broadcast to every cell of the row.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

// ===== rtl/core/mpq_cell.sv =====
// One slot of the sorted row: holds an entry and shifts it to or from its neighbours.
module mpq_cell #(
  parameter int unsigned DEPTH         = mpq_pkg::DepthDef,
  parameter int unsigned PRIORITY_BITS = mpq_pkg::PriorityBitsDef,
  parameter int unsigned TAG_BITS      = mpq_pkg::TagBitsDef,
  parameter int unsigned IDX           = 0
) (
  input  logic                             clk_i,
  input  mpq_pkg::op_e                     op_i,
  input  logic [$clog2(DEPTH+1)-1:0]       count_i,
  input  logic [PRIORITY_BITS-1:0]         new_prio_i,
  input  logic [TAG_BITS-1:0]              new_tag_i,
  input  logic                             left_keep_i,
  input  logic [PRIORITY_BITS-1:0]         left_prio_i,
  input  logic [TAG_BITS-1:0]              left_tag_i,
  input  logic [PRIORITY_BITS-1:0]         right_prio_i,
  input  logic [TAG_BITS-1:0]              right_tag_i,
  output logic                             keep_o,
  output logic [PRIORITY_BITS-1:0]         prio_o,
  output logic [TAG_BITS-1:0]              tag_o
);
  import mpq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [PRIORITY_BITS-1:0] prio_q, prio_d;
  logic [TAG_BITS-1:0]      tag_q, tag_d;
  logic                     occupied;

  // An occupied slot whose priority is at least the new one stays put, which
  // keeps equal priorities in arrival order.
  assign occupied = CntW'(IDX) < count_i;
  assign keep_o   = occupied && (prio_q >= new_prio_i);

  always_comb begin
    prio_d = prio_q;
    tag_d  = tag_q;
    case (op_i)
      OP_INSERT: begin
        if (!keep_o) begin
          if (left_keep_i) begin
            prio_d = new_prio_i;
            tag_d  = new_tag_i;
          end else begin
            prio_d = left_prio_i;
            tag_d  = left_tag_i;
          end
        end
      end
      OP_REMOVE: begin
        prio_d = right_prio_i;
        tag_d  = right_tag_i;
      end
      default: begin
        prio_d = prio_q;
        tag_d  = tag_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

  assign prio_o = prio_q;
  assign tag_o  = tag_q;

endmodule

// ===== rtl/core/max_priority_queue_core.sv =====
// Top level of the max priority queue: a row of sorting cells and the result register.
// Usage:
// The slave stream carries commands: an insert with a priority and a tag, or a
// remove, with the command kind on tuser. Every accepted transfer yields exactly
// one result transfer on the master stream with the status on tuser and the
// removed priority and tag (zero otherwise) and the number of entries held
// afterwards on tdata. Entries leave in descending priority order; equal
// priorities leave in arrival order.
// The result is registered: the result of a command accepted at one edge is valid
// after that edge. One command is taken every cycle while results drain; the
// row of cells updates all slots in parallel, each cell looking only at its
// neighbours and at the incoming command, so the rate is set by that single
// compare and shift per cell.
// A remove from an empty queue reports empty, an insert into a full queue is
// dropped and reported full; neither changes the contents.
// Reset empties the queue and drops any pending result; no clearing pass is
// needed. When the receiver stalls, the result stays in the output register and
// s_axis_tready_o drops until it is taken, so nothing is lost.
module max_priority_queue_core #(
  parameter int unsigned DEPTH         = mpq_pkg::DepthDef,
  parameter int unsigned PRIORITY_BITS = mpq_pkg::PriorityBitsDef,
  parameter int unsigned TAG_BITS      = mpq_pkg::TagBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // priority_req, entry_tag, then zero fill
  input  logic [((PRIORITY_BITS+TAG_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // command
  input  logic s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // out_priority, out_tag, occupancy, then zero fill
  output logic [((PRIORITY_BITS+TAG_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata_o,
  // status
  output logic [1:0] m_axis_tuser_o
);
  import mpq_pkg::*;

`include "max_priority_queue_core_defines.svh"

  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned OutW   = PRIORITY_BITS + TAG_BITS + CntW;
  localparam int unsigned OutTdW = ((OutW + 7) / 8) * 8;

  logic                     in_xfer;
  logic                     cmd;
  logic [PRIORITY_BITS-1:0] in_prio;
  logic [TAG_BITS-1:0]      in_tag;
  op_e                      op;
  status_e                  status;
  logic [CntW-1:0]          count_q, count_d;
  logic [PRIORITY_BITS-1:0] res_prio;
  logic [TAG_BITS-1:0]      res_tag;
  logic                     m_tvalid_q;
  logic [OutTdW-1:0]        m_tdata_q;
  status_e                  m_tuser_q;

  logic [PRIORITY_BITS-1:0] cell_prio [DEPTH];
  logic [TAG_BITS-1:0]      cell_tag  [DEPTH];
  logic [DEPTH-1:0]         cell_keep;

  assign s_axis_tready_o = !m_tvalid_q || m_axis_tready_i;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign cmd     = s_axis_tuser_i;
  assign in_prio = s_axis_tdata_i[PRIORITY_BITS-1:0];
  assign in_tag  = s_axis_tdata_i[PRIORITY_BITS+TAG_BITS-1:PRIORITY_BITS];

  always_comb begin
    op       = OP_HOLD;
    status   = ST_DONE;
    count_d  = count_q;
    res_prio = '0;
    res_tag  = '0;
    if (in_xfer) begin
      if (cmd == CmdInsert) begin
        if (count_q == CntW'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          op      = OP_INSERT;
          count_d = count_q + CntW'(1);
        end
      end else begin
        if (count_q == '0) begin
          status = ST_EMPTY;
        end else begin
          op       = OP_REMOVE;
          count_d  = count_q - CntW'(1);
          res_prio = cell_prio[0];
          res_tag  = cell_tag[0];
        end
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     left_keep;
    logic [PRIORITY_BITS-1:0] left_prio, right_prio;
    logic [TAG_BITS-1:0]      left_tag, right_tag;

    // The head has nothing to its left, so it behaves as if that side keeps.
    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_prio = in_prio;
      assign left_tag  = in_tag;
    end else begin : g_body
      assign left_keep = cell_keep[i-1];
      assign left_prio = cell_prio[i-1];
      assign left_tag  = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_prio = '0;
      assign right_tag  = '0;
    end else begin : g_inner
      assign right_prio = cell_prio[i+1];
      assign right_tag  = cell_tag[i+1];
    end

    mpq_cell #(
      .DEPTH        (DEPTH),
      .PRIORITY_BITS(PRIORITY_BITS),
      .TAG_BITS     (TAG_BITS),
      .IDX          (i)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .count_i     (count_q),
      .new_prio_i  (in_prio),
      .new_tag_i   (in_tag),
      .left_keep_i (left_keep),
      .left_prio_i (left_prio),
      .left_tag_i  (left_tag),
      .right_prio_i(right_prio),
      .right_tag_i (right_tag),
      .keep_o      (cell_keep[i]),
      .prio_o      (cell_prio[i]),
      .tag_o       (cell_tag[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_xfer) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      m_tdata_q <= OutTdW'({count_d, res_tag, res_prio});
      m_tuser_q <= status;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tuser_o  = m_tuser_q;

  `MPQ_ASSERT(a_count_bound, count_q <= CntW'(DEPTH))
  `MPQ_ASSERT(a_empty_remove,
    (in_xfer && cmd == CmdRemove && count_q == '0) |=> (m_tuser_q == ST_EMPTY))
  `MPQ_ASSERT(a_insert_grows,
    (in_xfer && cmd == CmdInsert && count_q != CntW'(DEPTH))
      |=> (count_q == $past(count_q) + CntW'(1)))
  `MPQ_ASSERT_ALWAYS(a_ready_when_idle, !m_tvalid_q |-> s_axis_tready_o)

endmodule
